// ----- src/mcat_pkg.sv -----
// ============================================================================
// Multicast address table package
// Sizes and codes shared by the multicast address table.
// ============================================================================
package mcat_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);

    localparam int ADDR_W      = 48;
    localparam int STATUS_W    = 2;
    localparam int ENTRY_CNT_W = 5;

    localparam logic MODE_ADD    = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_ADDED     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REMOVED   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [IDX_W-1:0]   idx_t;

endpackage

// ----- src/multicast_address_table.sv -----
// ============================================================================
// Multicast address table
// Compact list of multicast MAC addresses with add and remove requests.
// ============================================================================
// A request word is taken when start is high and busy is low; its result
// appears on status, entry_count and pass_all_mcast while done is high for
// exactly one cycle, and the receiver cannot stall it. An add request gives
// its result in the cycle after it is taken. A remove request walks the list
// in a memory with one write port and one registered read port: each entry
// compared passes through S_RD and S_CMP, then each later entry moved down
// passes through S_SHRD and S_SHWR. The next request can be taken in the
// cycle in which done is high.
module multicast_address_table
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                mode,
    input  logic [mcat_pkg::ADDR_W-1:0]         mac_address,
    output logic                                done,
    output logic [mcat_pkg::STATUS_W-1:0]       status,
    output logic [mcat_pkg::ENTRY_CNT_W-1:0]    entry_count,
    output logic                                pass_all_mcast
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_SHRD = 3'd3;
    localparam logic [2:0] S_SHWR = 3'd4;

    logic [2:0]                     state_reg, state_next;
    mcat_pkg::count_t               count_reg, count_next;
    mcat_pkg::count_t               ptr_reg, ptr_next;
    logic                           flag_reg, flag_next;
    logic                           done_reg, done_next;
    logic [mcat_pkg::STATUS_W-1:0]  status_reg, status_next;
    mcat_pkg::addr_t                key_reg, key_next;

    mcat_pkg::addr_t                mem_array [mcat_pkg::MAX_ENTRIES];
    mcat_pkg::addr_t                rd_data_reg;
    logic                           wr_en;
    mcat_pkg::idx_t                 wr_idx;
    mcat_pkg::addr_t                wr_data;
    mcat_pkg::idx_t                 rd_idx;
    logic [mcat_pkg::COUNT_W:0]     ptr_plus1;

    assign ptr_plus1 = {1'b0, ptr_reg} + 1'b1;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_idx] <= wr_data;
        end
        rd_data_reg <= mem_array[rd_idx];
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        flag_next   = flag_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        key_next    = key_reg;
        wr_en       = 1'b0;
        wr_idx      = count_reg[mcat_pkg::IDX_W-1:0];
        wr_data     = mac_address;
        rd_idx      = ptr_reg[mcat_pkg::IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    key_next = mac_address;
                    ptr_next = '0;
                    if (mode == mcat_pkg::MODE_ADD)
                    begin
                        flag_next = 1'b1;
                        done_next = 1'b1;
                        if (count_reg >= mcat_pkg::COUNT_W'(mcat_pkg::MAX_ENTRIES))
                        begin
                            status_next = mcat_pkg::ST_FULL;
                        end
                        else
                        begin
                            wr_en       = 1'b1;
                            count_next  = count_reg + 1'b1;
                            status_next = mcat_pkg::ST_ADDED;
                        end
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
            end
            S_RD:
            begin
                if (ptr_reg >= count_reg)
                begin
                    status_next = mcat_pkg::ST_NOT_FOUND;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (rd_data_reg == key_reg)
                begin
                    state_next = S_SHRD;
                end
                else
                begin
                    ptr_next   = ptr_plus1[mcat_pkg::COUNT_W-1:0];
                    state_next = S_RD;
                end
            end
            S_SHRD:
            begin
                rd_idx = ptr_plus1[mcat_pkg::IDX_W-1:0];
                if (ptr_plus1 >= {1'b0, count_reg})
                begin
                    count_next  = count_reg - 1'b1;
                    status_next = mcat_pkg::ST_REMOVED;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_SHWR;
                end
            end
            S_SHWR:
            begin
                wr_en      = 1'b1;
                wr_idx     = ptr_reg[mcat_pkg::IDX_W-1:0];
                wr_data    = rd_data_reg;
                ptr_next   = ptr_plus1[mcat_pkg::COUNT_W-1:0];
                state_next = S_SHRD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ptr_reg   <= '0;
            flag_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            flag_reg  <= flag_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        key_reg    <= key_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign status         = status_reg;
    assign entry_count    = mcat_pkg::ENTRY_CNT_W'(count_reg);
    assign pass_all_mcast = flag_reg;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Multicast address table testbench
// Sends add and remove request words through the start/busy handshake and
// checks every result word against a shadow copy of the address list, its
// count and the sticky pass-all flag. A short directed sequence covers the
// empty table, extreme addresses, duplicates, a full table and misses. It is
// followed by random traffic that keeps filling and draining the table.
// ============================================================================
module testbench;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 2 * mcat_pkg::MAX_ENTRIES + 8;
    localparam int RANDOM_WORDS   = 1950;
    localparam int POOL_SIZE      = 6;

    typedef struct packed {
        logic [mcat_pkg::STATUS_W-1:0]    status;
        logic [mcat_pkg::ENTRY_CNT_W-1:0] count;
        logic                             pass_all;
    } reply_t;

    logic                             clk;
    logic                             rst_n;
    logic                             start;
    logic                             busy;
    logic                             mode;
    mcat_pkg::addr_t                  mac_address;
    logic                             done;
    logic [mcat_pkg::STATUS_W-1:0]    status;
    logic [mcat_pkg::ENTRY_CNT_W-1:0] entry_count;
    logic                             pass_all_mcast;

    reply_t          reply_q[$];
    mcat_pkg::addr_t shadow_list[mcat_pkg::MAX_ENTRIES];
    int              shadow_count;
    logic            shadow_pass;
    int              errors;
    int              quiet_cycles;
    bit              idle_off;

    multicast_address_table dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .mode           (mode),
        .mac_address    (mac_address),
        .done           (done),
        .status         (status),
        .entry_count    (entry_count),
        .pass_all_mcast (pass_all_mcast)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic reply_t predict_reply(logic req_mode, mcat_pkg::addr_t addr);
        reply_t r;
        int     hit;
        hit = -1;
        if (req_mode == mcat_pkg::MODE_ADD)
        begin
            shadow_pass = 1'b1;
            if (shadow_count >= mcat_pkg::MAX_ENTRIES)
            begin
                r.status = mcat_pkg::ST_FULL;
            end
            else
            begin
                shadow_list[shadow_count] = addr;
                shadow_count++;
                r.status = mcat_pkg::ST_ADDED;
            end
        end
        else
        begin
            for (int i = 0; i < shadow_count; i++)
            begin
                if (hit < 0 && shadow_list[i] == addr)
                    hit = i;
            end
            if (hit < 0)
            begin
                r.status = mcat_pkg::ST_NOT_FOUND;
            end
            else
            begin
                for (int j = hit; j + 1 < shadow_count; j++)
                    shadow_list[j] = shadow_list[j + 1];
                shadow_count--;
                r.status = mcat_pkg::ST_REMOVED;
            end
        end
        r.count    = mcat_pkg::ENTRY_CNT_W'(shadow_count);
        r.pass_all = shadow_pass;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (idle_off || r < 50)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic mcat_pkg::addr_t random_addr();
        return mcat_pkg::addr_t'({$urandom, $urandom});
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        errors++;
    endtask

    task automatic send_word(logic req_mode, mcat_pkg::addr_t addr);
        int gap;
        start       <= 1'b1;
        mode        <= req_mode;
        mac_address <= addr;
        do
            @(posedge clk);
        while (busy);
        reply_q.push_back(predict_reply(req_mode, addr));
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (reply_q.size() != 0);
    endtask

    task automatic test_empty_remove();
        send_word(mcat_pkg::MODE_REMOVE, '0);
    endtask

    task automatic test_add_and_remove();
        send_word(mcat_pkg::MODE_ADD, '0);
        send_word(mcat_pkg::MODE_ADD, '1);
        send_word(mcat_pkg::MODE_ADD, 48'h0100_5E00_0001);
        send_word(mcat_pkg::MODE_ADD, 48'h0100_5E00_0001);
        send_word(mcat_pkg::MODE_REMOVE, 48'h0100_5E00_0001);
        send_word(mcat_pkg::MODE_REMOVE, 48'h3333_0000_0123);
    endtask

    task automatic test_full_table();
        while (shadow_count < mcat_pkg::MAX_ENTRIES)
            send_word(mcat_pkg::MODE_ADD,
                      48'h0100_5E7F_0000 | mcat_pkg::addr_t'(shadow_count));
        send_word(mcat_pkg::MODE_ADD, 48'hAAAA_5555_AAAA);
        send_word(mcat_pkg::MODE_REMOVE, shadow_list[mcat_pkg::MAX_ENTRIES - 1]);
        send_word(mcat_pkg::MODE_REMOVE, shadow_list[0]);
    endtask

    task automatic test_random_traffic(int words);
        mcat_pkg::addr_t pool[POOL_SIZE];
        bit              filling;
        bit              req_mode;
        mcat_pkg::addr_t addr;
        int              r;
        filling = 1'b1;
        for (int i = 0; i < POOL_SIZE; i++)
            pool[i] = random_addr();
        for (int n = 0; n < words; n++)
        begin
            if (n % 100 == 0)
                idle_off = ($urandom_range(0, 3) == 0);
            if (n % 250 == 249)
                wait_drained();
            if ($urandom_range(0, 99) < 5)
                filling = !filling;
            else if (shadow_count >= mcat_pkg::MAX_ENTRIES && $urandom_range(0, 99) < 30)
                filling = 1'b0;
            else if (shadow_count == 0 && $urandom_range(0, 99) < 30)
                filling = 1'b1;
            req_mode = ($urandom_range(0, 99) < (filling ? 70 : 30)) ?
                       mcat_pkg::MODE_ADD : mcat_pkg::MODE_REMOVE;
            r = $urandom_range(0, 99);
            if (req_mode == mcat_pkg::MODE_REMOVE && shadow_count > 0 && r < 75)
                addr = shadow_list[$urandom_range(0, shadow_count - 1)];
            else if (r < 30)
                addr = pool[$urandom_range(0, POOL_SIZE - 1)];
            else if (r < 40)
                addr = ($urandom_range(0, 1) == 0) ? mcat_pkg::addr_t'('0) :
                                                     mcat_pkg::addr_t'('1);
            else
                addr = random_addr();
            send_word(req_mode, addr);
        end
        idle_off = 1'b0;
    endtask

    always @(posedge clk)
    begin : check_reply
        reply_t want;
        if (rst_n && done)
        begin
            if (reply_q.size() == 0)
            begin
                report_mismatch($sformatf("result word with none expected: status %0d count %0d",
                                          status, entry_count));
            end
            else
            begin
                want = reply_q.pop_front();
                if (status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              status, want.status));
                if (entry_count !== want.count)
                    report_mismatch($sformatf("entry_count %0d, expected %0d",
                                              entry_count, want.count));
                if (pass_all_mcast !== want.pass_all)
                    report_mismatch($sformatf("pass_all_mcast %0d, expected %0d",
                                              pass_all_mcast, want.pass_all));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin
        errors       = 0;
        quiet_cycles = 0;
        idle_off     = 1'b0;
        shadow_count = 0;
        shadow_pass  = 1'b0;
        for (int i = 0; i < mcat_pkg::MAX_ENTRIES; i++)
            shadow_list[i] = '0;
        rst_n       <= 1'b0;
        start       <= 1'b0;
        mode        <= mcat_pkg::MODE_ADD;
        mac_address <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_remove();
        test_add_and_remove();
        test_full_table();
        wait_drained();
        test_random_traffic(RANDOM_WORDS);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
src/mcat_pkg.sv
src/multicast_address_table.sv
tb/testbench.sv
